// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cmix_pkg.sv =====
// ----------------------------------------------------------------------------
// Compressing mixer package
// Types and constants shared by the lane, merge, divide and power modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmix_pkg;

    localparam int COUNT_BITS = 4;

    typedef struct packed {
        logic                  neg;
        logic [COUNT_BITS-1:0] count;
    } cmix_ctl_t;

endpackage

// ===== src/cmix_lane.sv =====
// ----------------------------------------------------------------------------
// Compressing mixer voice lane
// Registers the sample of one voice, forced to zero when the lane is inactive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmix_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int LANE        = 0
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic [cmix_pkg::COUNT_BITS-1:0]      count,
    output logic signed [SAMPLE_BITS-1:0]        value_reg
);

    logic                          active;
    logic signed [SAMPLE_BITS-1:0] value_next;

    assign active     = count > cmix_pkg::COUNT_BITS'(LANE);
    assign value_next = active ? sample : '0;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== src/cmix_merge.sv =====
// ----------------------------------------------------------------------------
// Compressing mixer merge stage
// Adds the lane samples and registers the magnitude and sign of the sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmix_merge #(
    parameter int SAMPLE_BITS = 16,
    parameter int VOICES      = 8,
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(VOICES)
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic signed [SAMPLE_BITS-1:0]   lane_value [VOICES],
    input  logic [cmix_pkg::COUNT_BITS-1:0] count,
    output logic [SUM_BITS-1:0]             mag_reg,
    output cmix_pkg::cmix_ctl_t             ctl_reg
);

    logic signed [SUM_BITS-1:0] sum;
    logic [SUM_BITS-1:0]        mag_next;
    cmix_pkg::cmix_ctl_t        ctl_next;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            sum = sum + SUM_BITS'(lane_value[i]);
        end
        mag_next       = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
        ctl_next.neg   = sum[SUM_BITS-1];
        ctl_next.count = count;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= mag_next;
            ctl_reg <= ctl_next;
        end
    end

endmodule

// ===== src/cmix_div.sv =====
// ----------------------------------------------------------------------------
// Compressing mixer average divider
// Divides the sum magnitude by the voice count through an exact reciprocal
// multiply, then forms the distance of the average from full scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmix_div #(
    parameter int SAMPLE_BITS   = 16,
    parameter int VOICES        = 8,
    localparam int MAG_BITS     = SAMPLE_BITS + $clog2(VOICES)
) (
    input  logic                          clk,
    input  logic                          load_prod,
    input  logic                          load_gap,
    input  logic [MAG_BITS-1:0]           mag,
    input  cmix_pkg::cmix_ctl_t           ctl,
    output logic [SAMPLE_BITS-1:0]        gap_reg,
    output cmix_pkg::cmix_ctl_t           ctl_reg
);

    localparam int SHIFT      = MAG_BITS + 3;
    localparam int RECIP_BITS = SHIFT + 1;
    localparam int PROD_BITS  = MAG_BITS + RECIP_BITS;

    localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(64'd1 << SHIFT);
    localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(((64'd1 << SHIFT) + 64'd1) / 64'd2);
    localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'(((64'd1 << SHIFT) + 64'd2) / 64'd3);
    localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(((64'd1 << SHIFT) + 64'd3) / 64'd4);
    localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'(((64'd1 << SHIFT) + 64'd4) / 64'd5);
    localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'(((64'd1 << SHIFT) + 64'd5) / 64'd6);
    localparam logic [RECIP_BITS-1:0] RECIP_7 = RECIP_BITS'(((64'd1 << SHIFT) + 64'd6) / 64'd7);
    localparam logic [RECIP_BITS-1:0] RECIP_8 = RECIP_BITS'(((64'd1 << SHIFT) + 64'd7) / 64'd8);

    localparam logic [SAMPLE_BITS-1:0] ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [RECIP_BITS-1:0]  recip;
    logic [PROD_BITS-1:0]   prod_reg;
    cmix_pkg::cmix_ctl_t    ctl_prod_reg;
    logic [SAMPLE_BITS-1:0] quot;
    logic [SAMPLE_BITS-1:0] gap_next;
    cmix_pkg::cmix_ctl_t    ctl_next;

    always_comb
    begin
        case (ctl.count)
            4'd1:    recip = RECIP_1;
            4'd2:    recip = RECIP_2;
            4'd3:    recip = RECIP_3;
            4'd4:    recip = RECIP_4;
            4'd5:    recip = RECIP_5;
            4'd6:    recip = RECIP_6;
            4'd7:    recip = RECIP_7;
            4'd8:    recip = RECIP_8;
            default: recip = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            prod_reg     <= PROD_BITS'(mag) * PROD_BITS'(recip);
            ctl_prod_reg <= ctl;
        end
    end

    // A quotient of zero is a zero average, which counts as positive.
    always_comb
    begin
        quot           = prod_reg[SHIFT +: SAMPLE_BITS];
        gap_next       = ONE - quot;
        ctl_next.neg   = ctl_prod_reg.neg && (quot != '0);
        ctl_next.count = ctl_prod_reg.count;
    end

    always_ff @(posedge clk)
    begin
        if (load_gap)
        begin
            gap_reg <= gap_next;
            ctl_reg <= ctl_next;
        end
    end

endmodule

// ===== src/cmix_pow_stage.sv =====
// ----------------------------------------------------------------------------
// Compressing mixer power stage
// One truncated fixed point multiply of the running power by the distance,
// applied only while the step number is below the voice count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmix_pow_stage #(
    parameter int SAMPLE_BITS = 16,
    parameter int STEP        = 1
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic [SAMPLE_BITS-1:0] gap,
    input  logic [SAMPLE_BITS-1:0] pow,
    input  cmix_pkg::cmix_ctl_t    ctl,
    output logic [SAMPLE_BITS-1:0] gap_reg,
    output logic [SAMPLE_BITS-1:0] pow_reg,
    output cmix_pkg::cmix_ctl_t    ctl_reg
);

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int PROD_BITS = 2 * SAMPLE_BITS;

    logic [PROD_BITS-1:0]   prod;
    logic [SAMPLE_BITS-1:0] pow_next;

    assign prod     = PROD_BITS'(pow) * PROD_BITS'(gap);
    assign pow_next = (cmix_pkg::COUNT_BITS'(STEP) < ctl.count) ?
                      prod[FRAC_BITS +: SAMPLE_BITS] : pow;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            gap_reg <= gap;
            pow_reg <= pow_next;
            ctl_reg <= ctl;
        end
    end

endmodule

// ===== src/multi_voice_compressing_mixer_top.sv =====
// ----------------------------------------------------------------------------
// Multi-voice compressing mixer
// Averages up to VOICES active voice samples and applies the compressing
// curve sign(avg) * (1 - (1 - |avg|)^count) with saturation.
// ----------------------------------------------------------------------------
// The mixer takes one item per clock while the output is not stalled and
// returns one result per item, in order. Each item passes the merge
// adder, the two-step reciprocal divider, the VOICES - 1 registered
// multipliers of the power chain and the output register, all behind the lane
// register that takes the item; each pipeline stage holds one item, so the
// block keeps accepting items while a result waits at the output as long as
// some stage is empty.
`timescale 1ns / 1ps

module multi_voice_compressing_mixer_top #(
    parameter int VOICES      = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_0,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_1,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_2,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_3,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_4,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_5,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_6,
    input  logic signed [SAMPLE_BITS-1:0]   voice_sample_7,
    input  logic [cmix_pkg::COUNT_BITS-1:0] active_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   mixed_sample
);

    localparam int MAX_LANES  = 8;
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(VOICES);
    localparam int NSTAGES    = VOICES + 4;
    localparam int LAST       = NSTAGES - 1;
    localparam int ST_MERGE   = 1;
    localparam int ST_PROD    = 2;
    localparam int ST_POW     = 3;

    localparam logic [SAMPLE_BITS-1:0] ONE     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic signed [SAMPLE_BITS-1:0]   sample_in [MAX_LANES];
    logic signed [SAMPLE_BITS-1:0]   lane_value [VOICES];
    logic [cmix_pkg::COUNT_BITS-1:0] count_clamped;
    logic [cmix_pkg::COUNT_BITS-1:0] count_reg;
    logic [SUM_BITS-1:0]             mag;
    cmix_pkg::cmix_ctl_t             merge_ctl;
    logic [SAMPLE_BITS-1:0]          gap_stage [VOICES];
    logic [SAMPLE_BITS-1:0]          pow_stage [VOICES];
    cmix_pkg::cmix_ctl_t             ctl_stage [VOICES];

    logic [NSTAGES-1:0]              valid_reg;
    logic [NSTAGES-1:0]              valid_next;
    logic [NSTAGES-1:0]              advance;

    logic [SAMPLE_BITS-1:0]          result_mag;
    logic [SAMPLE_BITS-1:0]          result_next;
    logic [SAMPLE_BITS-1:0]          result_reg;

    assign sample_in[0] = voice_sample_0;
    assign sample_in[1] = voice_sample_1;
    assign sample_in[2] = voice_sample_2;
    assign sample_in[3] = voice_sample_3;
    assign sample_in[4] = voice_sample_4;
    assign sample_in[5] = voice_sample_5;
    assign sample_in[6] = voice_sample_6;
    assign sample_in[7] = voice_sample_7;

    assign count_clamped = (active_count > cmix_pkg::COUNT_BITS'(VOICES)) ?
                           cmix_pkg::COUNT_BITS'(VOICES) : active_count;

    // A stage loads when it is empty or its item moves on in the same cycle.
    always_comb
    begin
        advance[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            advance[i] = !valid_reg[i] || advance[i+1];
        end
        valid_next[0] = advance[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NSTAGES; i++)
        begin
            valid_next[i] = advance[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < VOICES; g++)
        begin : g_lane
            cmix_lane #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .LANE       (g)
            ) u_lane (
                .clk      (clk),
                .load     (advance[0]),
                .sample   (sample_in[g]),
                .count    (count_clamped),
                .value_reg(lane_value[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            count_reg <= count_clamped;
        end
    end

    cmix_merge #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .VOICES     (VOICES)
    ) u_merge (
        .clk       (clk),
        .load      (advance[ST_MERGE]),
        .lane_value(lane_value),
        .count     (count_reg),
        .mag_reg   (mag),
        .ctl_reg   (merge_ctl)
    );

    cmix_div #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .VOICES     (VOICES)
    ) u_div (
        .clk      (clk),
        .load_prod(advance[ST_PROD]),
        .load_gap (advance[ST_POW]),
        .mag      (mag),
        .ctl      (merge_ctl),
        .gap_reg  (gap_stage[0]),
        .ctl_reg  (ctl_stage[0])
    );

    assign pow_stage[0] = gap_stage[0];

    generate
        for (g = 1; g < VOICES; g++)
        begin : g_pow
            cmix_pow_stage #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .STEP       (g)
            ) u_pow (
                .clk     (clk),
                .load    (advance[ST_POW + g]),
                .gap     (gap_stage[g-1]),
                .pow     (pow_stage[g-1]),
                .ctl     (ctl_stage[g-1]),
                .gap_reg (gap_stage[g]),
                .pow_reg (pow_stage[g]),
                .ctl_reg (ctl_stage[g])
            );
        end
    endgenerate

    // A positive full-scale magnitude saturates to the largest positive sample.
    always_comb
    begin
        result_mag = ONE - pow_stage[VOICES-1];
        if (ctl_stage[VOICES-1].neg)
        begin
            result_next = SAMPLE_BITS'(~result_mag + 1'b1);
        end
        else if (result_mag == ONE)
        begin
            result_next = POS_MAX;
        end
        else
        begin
            result_next = result_mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[LAST])
        begin
            result_reg <= result_next;
        end
    end

    assign in_ready     = advance[0];
    assign out_valid    = valid_reg[LAST];
    assign mixed_sample = signed'(result_reg);

endmodule

// ===== src/cmix_checker.sv =====
// ----------------------------------------------------------------------------
// Compressing mixer port checker
// Watches the handshake ports of the mixer for stalls and back pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmix_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] mixed_sample
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(mixed_sample), "stalled result changed")
    `ASSERT_SAME(a_ready_when_empty_out, clk, rst_n, !in_ready,
                 out_valid && !out_ready, "input blocked without an output stall")
    `ASSERT_NEXT(a_full_keeps_result, clk, rst_n, !in_ready,
                 out_valid && $stable(mixed_sample), "full pipeline dropped its result")

endmodule

bind multi_voice_compressing_mixer_top cmix_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_cmix_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mixed_sample(mixed_sample)
);
